// ===== rtl/rectangle_rasterizer_top_assert.svh =====
// assertion macros for the rectangle rasterizer
`ifndef RECTANGLE_RASTERIZER_TOP_ASSERT_SVH
`define RECTANGLE_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rr_pkg.sv =====
// shared types, codes and sizing helpers for the rectangle rasterizer
`default_nettype none

package rr_pkg;

  // default geometry
  localparam int MAX_DIM_DEFAULT   = 256;
  localparam int FRAC_BITS_DEFAULT = 8;

  // fixed field widths
  localparam int FIX_W  = 20;
  localparam int CHAR_W = 8;
  localparam int CFG_W  = 9;

  // register reset values
  localparam int DIM_RESET = 256;
  localparam logic [CHAR_W-1:0] BG_RESET = 8'd32;

  // shape characters
  localparam logic [CHAR_W-1:0] SHAPE_FILLED  = 8'd82;
  localparam logic [CHAR_W-1:0] SHAPE_OUTLINE = 8'd114;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_REJECT = 2'd1,
    STS_RANGE  = 2'd2,
    STS_SPARE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_WIDTH      = 2'd0,
    CFG_HEIGHT     = 2'd1,
    CFG_BACKGROUND = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DONE
  } state_t;

  // control into the coverage unit
  typedef struct packed {
    logic load;
    logic filled;
  } cover_ctl_t;

  // bits of one pixel coordinate
  function automatic int coord_width(input int max_dim);
    return (max_dim > 1) ? $clog2(max_dim) : 1;
  endfunction

  // signed width that holds coordinates, corners and far edges
  function automatic int cmp_width(input int max_dim, input int frac);
    int cw;
    cw = coord_width(max_dim);
    return (cw + frac + 2 > FIX_W + 3) ? cw + frac + 2 : FIX_W + 3;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rr_canvas_mem.sv =====
// canvas memory: one write port, one registered read port
`default_nettype none

module rr_canvas_mem #(
  parameter int ADDR_W = 16
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [rr_pkg::CHAR_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [ADDR_W-1:0]         raddr,
  output logic      [rr_pkg::CHAR_W-1:0] rdata
);
  import rr_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [CHAR_W-1:0] mem [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rr_cover.sv =====
// rectangle coverage unit: holds edge thresholds, tests one pixel per cycle
`default_nettype none

module rr_cover #(
  parameter int MAX_DIM   = rr_pkg::MAX_DIM_DEFAULT,
  parameter int FRAC_BITS = rr_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                                       clk,
  input  wire rr_pkg::cover_ctl_t                         ctl,
  input  wire logic signed [rr_pkg::FIX_W-1:0]            rect_x,
  input  wire logic signed [rr_pkg::FIX_W-1:0]            rect_y,
  input  wire logic signed [rr_pkg::FIX_W-1:0]            rect_w,
  input  wire logic signed [rr_pkg::FIX_W-1:0]            rect_h,
  input  wire logic [rr_pkg::coord_width(MAX_DIM)-1:0]    col,
  input  wire logic [rr_pkg::coord_width(MAX_DIM)-1:0]    row,
  output logic                                            hit
);
  import rr_pkg::*;

  localparam int CMP_W = cmp_width(MAX_DIM, FRAC_BITS);
  localparam logic signed [CMP_W-1:0] ONE_FX = CMP_W'(1) << FRAC_BITS;

  logic signed [CMP_W-1:0] xlo_r, xlo1_r, xhi_r, xhi1_r;
  logic signed [CMP_W-1:0] ylo_r, ylo1_r, yhi_r, yhi1_r;
  logic                    filled_r;
  logic signed [CMP_W-1:0] x_ext, y_ext, xe_ext, ye_ext;
  logic signed [CMP_W-1:0] px, py;
  logic                    covered, edge_near;

  // far edges of the rectangle
  assign x_ext  = CMP_W'(rect_x);
  assign y_ext  = CMP_W'(rect_y);
  assign xe_ext = x_ext + CMP_W'(rect_w);
  assign ye_ext = y_ext + CMP_W'(rect_h);

  // thresholds captured when a draw starts
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      xlo_r    <= x_ext;
      xlo1_r   <= x_ext + ONE_FX;
      xhi_r    <= xe_ext;
      xhi1_r   <= xe_ext - ONE_FX;
      ylo_r    <= y_ext;
      ylo1_r   <= y_ext + ONE_FX;
      yhi_r    <= ye_ext;
      yhi1_r   <= ye_ext - ONE_FX;
      filled_r <= ctl.filled;
    end
  end

  // pixel position in fixed point
  assign px = CMP_W'(col) << FRAC_BITS;
  assign py = CMP_W'(row) << FRAC_BITS;

  // covered, and within one unit of some edge
  assign covered   = (px >= xlo_r) && (px <= xhi_r) && (py >= ylo_r) && (py <= yhi_r);
  assign edge_near = (px < xlo1_r) || (py < ylo1_r) || (px > xhi1_r) || (py > yhi1_r);
  assign hit       = covered && (filled_r || edge_near);

endmodule

`default_nettype wire

// ===== rtl/rectangle_rasterizer_top.sv =====
// Rectangle rasterizer over a byte-per-pixel canvas held in one synchronous
// memory. A clear or a draw sweeps the active canvas_width by canvas_height
// area at one pixel per cycle through the single canvas write port, then
// finishes and passes its result to the output register; a read goes through
// the registered memory access and a read-wait state first, and a rejected
// draw, a read outside the canvas and op 3 go straight to the done state. One
// item is worked at a time; the next item is accepted once the sequencer is
// idle again after the previous result moved into the output register. A
// result still waiting in the output register holds the next finished result
// back. The canvas needs no clearing pass after reset, but pixels read before
// any clear or draw wrote them hold unknown data.
`default_nettype none

module rectangle_rasterizer_top #(
  parameter int MAX_DIM   = rr_pkg::MAX_DIM_DEFAULT,
  parameter int FRAC_BITS = rr_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [rr_pkg::CFG_W-1:0]          cfg_data,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_op,
  input  wire logic [rr_pkg::CHAR_W-1:0]         in_shape_char,
  input  wire logic signed [rr_pkg::FIX_W-1:0]   in_rect_x,
  input  wire logic signed [rr_pkg::FIX_W-1:0]   in_rect_y,
  input  wire logic signed [rr_pkg::FIX_W-1:0]   in_rect_w,
  input  wire logic signed [rr_pkg::FIX_W-1:0]   in_rect_h,
  input  wire logic [rr_pkg::CHAR_W-1:0]         in_paint_char,
  input  wire logic [7:0]                        in_pixel_col,
  input  wire logic [7:0]                        in_pixel_row,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             out_status,
  output logic [rr_pkg::CHAR_W-1:0]              out_pixel_value
);
  import rr_pkg::*;

  localparam int CW     = coord_width(MAX_DIM);
  localparam int ADDR_W = 2 * CW;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = cmp_width(MAX_DIM, FRAC_BITS);
  localparam int DIM_RST_CLAMP = (DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET;
  localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(DIM_RST_CLAMP);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
  localparam logic signed [CMP_W-1:0] ONE_FX = CMP_W'(1) << FRAC_BITS;

  state_t            state_r, state_nxt;
  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  logic [CHAR_W-1:0] bg_r, bg_nxt;
  logic [CW-1:0]     col_r, row_r;
  logic              clear_mode_r;
  logic [CHAR_W-1:0] paint_r;
  status_t           res_status_r;
  logic [CHAR_W-1:0] res_pixel_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [CHAR_W-1:0] out_pixel_r;

  logic              accept, out_free;
  logic              scan_active, read_wait, result_load;
  logic              col_end, row_end, scan_last;
  logic              draw_bad, read_bad;
  logic              mem_we, mem_re;
  logic [CHAR_W-1:0] mem_rdata;
  logic              hit;
  op_t               op;
  cover_ctl_t        cover_ctl;
  logic [DIM_W-1:0]  cfg_dim;

  assign op       = op_t'(in_op);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // configuration is always taken; the user must write it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  // canvas size written to a register, clamped to 1..MAX_DIM
  always_comb begin
    priority if (cfg_data == '0) begin
      cfg_dim = DIM_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_DIM)) begin
      cfg_dim = DIM_MAX;
    end else begin
      cfg_dim = DIM_W'(cfg_data);
    end
  end

  // configuration register updates
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    bg_nxt     = bg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:      width_nxt  = cfg_dim;
        CFG_HEIGHT:     height_nxt = cfg_dim;
        CFG_BACKGROUND: bg_nxt     = cfg_data[CHAR_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RST;
      height_r <= DIM_RST;
      bg_r     <= BG_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bg_r     <= bg_nxt;
    end
  end

  // checks made when an item arrives
  assign draw_bad = (CMP_W'(in_rect_w) < ONE_FX) || (CMP_W'(in_rect_h) < ONE_FX) ||
                    ((in_shape_char != SHAPE_FILLED) && (in_shape_char != SHAPE_OUTLINE));
  assign read_bad = (32'(in_pixel_col) >= 32'(width_r)) ||
                    (32'(in_pixel_row) >= 32'(height_r));

  // scan position limits
  assign col_end   = DIM_W'(col_r) == (width_r - DIM_W'(1));
  assign row_end   = DIM_W'(row_r) == (height_r - DIM_W'(1));
  assign scan_last = col_end && row_end;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_CLEAR: state_nxt = S_SCAN;
            OP_DRAW:  state_nxt = draw_bad ? S_DONE : S_SCAN;
            OP_READ:  state_nxt = read_bad ? S_DONE : S_READ;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready    = 1'b0;
    scan_active = 1'b0;
    read_wait   = 1'b0;
    result_load = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready    = 1'b1;
      S_SCAN:  scan_active = 1'b1;
      S_READ:  read_wait   = 1'b1;
      S_DONE:  result_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // coverage unit loads its thresholds with each draw
  assign cover_ctl.load   = accept && (op == OP_DRAW);
  assign cover_ctl.filled = in_shape_char == SHAPE_FILLED;

  rr_cover #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_cover (
    .clk    (clk),
    .ctl    (cover_ctl),
    .rect_x (in_rect_x),
    .rect_y (in_rect_y),
    .rect_w (in_rect_w),
    .rect_h (in_rect_h),
    .col    (col_r),
    .row    (row_r),
    .hit    (hit)
  );

  // canvas access: scan writes and reads never overlap, one item at a time
  assign mem_we = scan_active && (clear_mode_r || hit);
  assign mem_re = accept && (op == OP_READ);

  rr_canvas_mem #(
    .ADDR_W (ADDR_W)
  ) u_canvas (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({row_r, col_r}),
    .wdata (clear_mode_r ? bg_r : paint_r),
    .re    (mem_re),
    .raddr ({CW'(in_pixel_row), CW'(in_pixel_col)}),
    .rdata (mem_rdata)
  );

  // item datapath: scan counters and pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      clear_mode_r <= op == OP_CLEAR;
      paint_r      <= in_paint_char;
      col_r        <= '0;
      row_r        <= '0;
      res_pixel_r  <= '0;
      unique case (op)
        OP_DRAW: res_status_r <= draw_bad ? STS_REJECT : STS_OK;
        OP_READ: res_status_r <= read_bad ? STS_RANGE : STS_OK;
        default: res_status_r <= STS_OK;
      endcase
    end else if (scan_active) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_r + CW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end else if (read_wait) begin
      res_pixel_r <= mem_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_status_r <= res_status_r;
      out_pixel_r  <= res_pixel_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_pixel_value = out_pixel_r;

  `include "rectangle_rasterizer_top_assert.svh"

  `RR_ASSERT_NEXT(a_busy_after_accept, accept, state_r != S_IDLE,
                  "accepted item left the sequencer idle")
  `RR_ASSERT_NOW(a_scan_in_canvas, scan_active,
                 (DIM_W'(col_r) < width_r) && (DIM_W'(row_r) < height_r),
                 "scan position outside active canvas")
  `RR_ASSERT_NOW(a_write_only_scan, mem_we, state_r == S_SCAN,
                 "canvas written outside a scan")
  `RR_ASSERT_NOW(a_result_from_done, $rose(out_valid_r), $past(state_r) == S_DONE,
                 "result presented without finishing an item")

endmodule

`default_nettype wire
